// ===== hdl/assert_macros.svh =====
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AWM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define AWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/awm_pkg.sv =====
package awm_pkg;

    localparam int SYM_W           = 5;
    localparam int KIND_W          = 2;
    localparam int AWM_MAX_PATTERN = 64;
    localparam int AWM_ALPHABET    = 26;

    typedef enum logic [KIND_W-1:0] {
        KIND_PATTERN = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_CLEAR   = 2'd2
    } awm_kind_t;

    typedef struct packed {
        logic             clear;
        logic             empty;
        logic             req_add;
        logic             win_add;
        logic             win_sub;
        logic [SYM_W-1:0] add_sym;
        logic [SYM_W-1:0] sub_sym;
    } awm_cell_ctrl_t;

endpackage

// ===== hdl/awm_if.sv =====
interface awm_item_if import awm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;

    modport source (output valid, output kind, output symbol, input ready);
    modport sink   (input valid, input kind, input symbol, output ready);
endinterface

interface awm_result_if ();
    logic valid;
    logic ready;
    logic window_match;
    logic found;
    logic pattern_overflow;

    modport source (output valid, output window_match, output found,
                    output pattern_overflow, input ready);
    modport sink   (input valid, input window_match, input found,
                    input pattern_overflow, output ready);
endinterface

// ===== hdl/awm_letter_cell.sv =====
module awm_letter_cell import awm_pkg::*; #(
    parameter int CW    = 7,
    parameter int CMP_W = 5,
    parameter int IDX   = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  awm_cell_ctrl_t ctrl,
    output logic           eq_next
);

    logic [CW-1:0] req_reg;
    logic [CW-1:0] req_next;
    logic [CW-1:0] win_reg;
    logic [CW-1:0] win_next;
    logic          hit_add;
    logic          hit_sub;

    assign hit_add = ctrl.win_add && (CMP_W'(ctrl.add_sym) == CMP_W'(IDX));
    assign hit_sub = ctrl.win_sub && (CMP_W'(ctrl.sub_sym) == CMP_W'(IDX));

    always_comb
    begin
        req_next = req_reg;
        win_next = win_reg;
        if (ctrl.clear)
        begin
            req_next = '0;
            win_next = '0;
        end
        else if (ctrl.empty)
        begin
            win_next = '0;
            if (ctrl.req_add && (CMP_W'(ctrl.add_sym) == CMP_W'(IDX)))
            begin
                req_next = req_reg + CW'(1);
            end
        end
        else if (hit_add && !hit_sub)
        begin
            win_next = win_reg + CW'(1);
        end
        else if (hit_sub && !hit_add && (win_reg != '0))
        begin
            win_next = win_reg - CW'(1);
        end
    end

    assign eq_next = (win_next == req_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= '0;
            win_reg <= '0;
        end
        else
        begin
            req_reg <= req_next;
            win_reg <= win_next;
        end
    end

endmodule

// ===== hdl/awm_ring.sv =====
module awm_ring import awm_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [SYM_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [SYM_W-1:0] rdata
);

    logic [SYM_W-1:0] mem [DEPTH];
    logic [SYM_W-1:0] rdata_reg;

    // write-through when the slot read next is the one written now
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/anagram_window_matcher.sv =====
// Sliding-window anagram search over a letter stream.
// item channel (sink): kind selects pattern letter, text letter or clear;
//   symbol is the letter index. Pattern letters build the per-letter
//   required counts and empty the window; text letters slide a window of
//   pattern length and are checked for being a permutation of the pattern.
// result channel (source): one result per request, in order: window_match,
//   sticky found since the last pattern letter or clear, pattern_overflow
//   when a pattern letter was dropped.
// Pipeline: a request passes the input register, then the result register.
//   Throughput is one request per cycle while result.ready is high, set by
//   the per-letter counter cells and the one-read ring memory whose read
//   address is prefetched from the next state.
// Stall: a pending result holds while result.ready is low; one more request
//   is taken into the input register, then item.ready drops.
// Reset: all counts, lengths, valid flags and the found flag clear at once; the ring memory needs
//   no clearing since only slots written since the window was emptied are read.
`include "assert_macros.svh"

module anagram_window_matcher import awm_pkg::*; #(
    parameter int MAX_PATTERN = AWM_MAX_PATTERN,
    parameter int ALPHABET    = AWM_ALPHABET
) (
    input  logic         clk,
    input  logic         rst_n,
    awm_item_if.sink     item,
    awm_result_if.source result
);

    localparam int LW    = $clog2(MAX_PATTERN + 1);
    localparam int PW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int AB_W  = $clog2(ALPHABET + 1);
    localparam int CMP_W = (SYM_W > AB_W) ? SYM_W : AB_W;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [SYM_W-1:0]  s1_sym_reg;

    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     len_next;
    logic [LW-1:0]     fill_reg;
    logic [LW-1:0]     fill_next;
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    logic [PW-1:0]     pos_inc;
    logic              seen_reg;
    logic              seen_base;
    logic              seen_next;

    logic              o_valid_reg;
    logic              o_valid_next;
    logic              o_match_reg;
    logic              o_found_reg;
    logic              o_ovf_reg;

    logic              advance;
    logic              take;
    logic              sym_ok;
    logic              old_ok;
    logic              text_step;
    logic              win_match;
    logic              ovf;
    logic              we;
    logic [SYM_W-1:0]  rd_sym;
    logic [PW-1:0]     raddr;
    logic [LW:0]       pos_ext;
    logic [LW:0]       len_ext;
    logic [LW:0]       raddr_sum;
    logic [ALPHABET-1:0] eq_vec;
    awm_cell_ctrl_t    ctrl;

    assign advance    = s1_valid_reg && (!o_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign take       = item.valid && item.ready;

    assign s1_valid_next = take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign o_valid_next  = advance ? 1'b1 : (result.ready ? 1'b0 : o_valid_reg);

    assign sym_ok  = CMP_W'(s1_sym_reg) < CMP_W'(ALPHABET);
    assign old_ok  = CMP_W'(rd_sym) < CMP_W'(ALPHABET);
    assign pos_inc = (pos_reg == PW'(MAX_PATTERN - 1)) ? '0 : pos_reg + PW'(1);

    always_comb
    begin
        ctrl         = '0;
        ctrl.add_sym = s1_sym_reg;
        ctrl.sub_sym = rd_sym;
        len_next     = len_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        seen_base    = seen_reg;
        ovf          = 1'b0;
        we           = 1'b0;
        text_step    = 1'b0;
        if (advance)
        begin
            case (awm_kind_t'(s1_kind_reg))
                KIND_PATTERN:
                begin
                    ctrl.empty = 1'b1;
                    fill_next  = '0;
                    pos_next   = '0;
                    seen_base  = 1'b0;
                    if (sym_ok && (len_reg < LW'(MAX_PATTERN)))
                    begin
                        ctrl.req_add = 1'b1;
                        len_next     = len_reg + LW'(1);
                    end
                    else
                    begin
                        ovf = 1'b1;
                    end
                end
                KIND_TEXT:
                begin
                    if (len_reg != '0)
                    begin
                        if (!sym_ok)
                        begin
                            ctrl.empty = 1'b1;
                            fill_next  = '0;
                            pos_next   = '0;
                        end
                        else
                        begin
                            if (fill_reg >= len_reg)
                            begin
                                ctrl.win_sub = old_ok;
                            end
                            else
                            begin
                                fill_next = fill_reg + LW'(1);
                            end
                            ctrl.win_add = 1'b1;
                            we           = 1'b1;
                            pos_next     = pos_inc;
                            text_step    = 1'b1;
                        end
                    end
                end
                KIND_CLEAR:
                begin
                    ctrl.clear = 1'b1;
                    len_next   = '0;
                    fill_next  = '0;
                    pos_next   = '0;
                    seen_base  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign win_match = text_step && (fill_next == len_reg) && (&eq_vec);
    assign seen_next = seen_base || win_match;

    // oldest slot of the window after this step
    assign pos_ext   = (LW + 1)'(pos_next);
    assign len_ext   = (LW + 1)'(len_next);
    assign raddr_sum = (pos_ext >= len_ext) ? (pos_ext - len_ext)
                                            : (pos_ext + (LW + 1)'(MAX_PATTERN) - len_ext);
    assign raddr     = raddr_sum[PW-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < ALPHABET; gi++)
        begin : g_cell
            awm_letter_cell #(
                .CW    (LW),
                .CMP_W (CMP_W),
                .IDX   (gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .eq_next (eq_vec[gi])
            );
        end
    endgenerate

    awm_ring #(
        .DEPTH (MAX_PATTERN),
        .AW    (PW)
    ) u_ring (
        .clk   (clk),
        .we    (we),
        .waddr (pos_reg),
        .wdata (s1_sym_reg),
        .raddr (raddr),
        .rdata (rd_sym)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            len_reg      <= '0;
            fill_reg     <= '0;
            pos_reg      <= '0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
            len_reg      <= len_next;
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            seen_reg     <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_kind_reg <= item.kind;
            s1_sym_reg  <= item.symbol;
        end
        if (advance)
        begin
            o_match_reg <= win_match;
            o_found_reg <= seen_next;
            o_ovf_reg   <= ovf;
        end
    end

    assign result.valid            = o_valid_reg;
    assign result.window_match     = o_match_reg;
    assign result.found            = o_found_reg;
    assign result.pattern_overflow = o_ovf_reg;

    `AWM_ASSERT_IMPLIES(a_match_found, result.valid && result.window_match, result.found)
    `AWM_ASSERT_IMPLIES(a_ovf_quiet, result.valid && result.pattern_overflow,
                        !result.window_match && !result.found)
    `AWM_ASSERT_IMPLIES(a_fill_bound, 1'b1,
                        (fill_reg <= len_reg) && (len_reg <= LW'(MAX_PATTERN)))
    `AWM_ASSERT_NEXT(a_stage_full, s1_valid_reg && !advance, s1_valid_reg && o_valid_reg)

endmodule

// ===== bench/anagram_window_matcher_tb.sv =====
`timescale 1ns / 1ps

module anagram_window_matcher_tb;
    import awm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int RANDOM_LETTERS = 2000;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int REPORT_MAX     = 10;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  symbol;
        bit                hold;
    } letter_req_t;

    typedef struct {
        bit window_match;
        bit found;
        bit pattern_overflow;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    awm_item_if   item_ch ();
    awm_result_if result_ch ();

    anagram_window_matcher DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    always #10 clk = ~clk;

    letter_req_t outgoing_letters[$];
    verdict_t    expected_verdicts[$];

    // shadow of the search state
    bit [6:0] need_cnt[AWM_ALPHABET];
    bit [6:0] win_cnt[AWM_ALPHABET];
    bit [4:0] history[AWM_MAX_PATTERN];
    bit [6:0] pat_len;
    bit [6:0] win_fill;
    bit [5:0] ring_wr;
    bit [4:0] mismatch_letters;
    bit       seen_match;

    int  queued_count;
    int  accepted_count;
    int  checked_count;
    int  match_count;
    int  overflow_count;
    int  error_count;
    int  cycle_count;
    bit  hold_next;

    task automatic reset_search();
        int i;
        for (i = 0; i < AWM_ALPHABET; i++)
        begin
            need_cnt[i] = '0;
            win_cnt[i]  = '0;
        end
        for (i = 0; i < AWM_MAX_PATTERN; i++)
            history[i] = '0;
        pat_len          = '0;
        win_fill         = '0;
        ring_wr          = '0;
        mismatch_letters = '0;
        seen_match       = 1'b0;
    endtask

    task automatic clear_window();
        int i;
        mismatch_letters = '0;
        for (i = 0; i < AWM_ALPHABET; i++)
        begin
            win_cnt[i] = '0;
            if (need_cnt[i] != 0)
                mismatch_letters++;
        end
        win_fill = '0;
        ring_wr  = '0;
    endtask

    task automatic tally_letter(input int s, input bit add);
        if (win_cnt[s] == need_cnt[s])
            mismatch_letters++;
        if (add)
            win_cnt[s]++;
        else if (win_cnt[s] != 0)
            win_cnt[s]--;
        if (win_cnt[s] == need_cnt[s] && mismatch_letters != 0)
            mismatch_letters--;
    endtask

    task automatic predict_verdict(input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] s);
        verdict_t v;
        int oldest;
        v = '{window_match: 1'b0, found: 1'b0, pattern_overflow: 1'b0};
        case (k)
            KIND_PATTERN:
            begin
                if (s < AWM_ALPHABET && pat_len < AWM_MAX_PATTERN)
                begin
                    need_cnt[s]++;
                    pat_len++;
                end
                else
                    v.pattern_overflow = 1'b1;
                seen_match = 1'b0;
                clear_window();
            end
            KIND_TEXT:
            begin
                if (pat_len != 0)
                begin
                    if (s >= AWM_ALPHABET)
                        clear_window();
                    else
                    begin
                        if (win_fill >= pat_len)
                        begin
                            oldest = (ring_wr + AWM_MAX_PATTERN - pat_len) % AWM_MAX_PATTERN;
                            if (history[oldest] < AWM_ALPHABET)
                                tally_letter(history[oldest], 1'b0);
                        end
                        else
                            win_fill++;
                        tally_letter(s, 1'b1);
                        history[ring_wr] = s;
                        ring_wr++;
                        if (win_fill == pat_len && mismatch_letters == 0)
                        begin
                            v.window_match = 1'b1;
                            seen_match     = 1'b1;
                        end
                    end
                end
            end
            KIND_CLEAR:
                reset_search();
            default: ;
        endcase
        v.found = seen_match;
        expected_verdicts.push_back(v);
    endtask

    function automatic bit take_break();
        if (accepted_count >= 900 && accepted_count < 1300)
            return 1'b0;
        return $urandom_range(99) < 23;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid  <= 1'b0;
            item_ch.kind   <= KIND_PATTERN;
            item_ch.symbol <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predict_verdict(item_ch.kind, item_ch.symbol);
                accepted_count++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (outgoing_letters.size() != 0 && !take_break() &&
                    !(outgoing_letters[0].hold && expected_verdicts.size() != 0))
                begin
                    item_ch.valid  <= 1'b1;
                    item_ch.kind   <= outgoing_letters[0].kind;
                    item_ch.symbol <= outgoing_letters[0].symbol;
                    void'(outgoing_letters.pop_front());
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("result %0d arrived with nothing expected", checked_count);
                end
                else
                begin
                    verdict_t v;
                    v = expected_verdicts.pop_front();
                    if (result_ch.window_match !== v.window_match ||
                        result_ch.found !== v.found ||
                        result_ch.pattern_overflow !== v.pattern_overflow)
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("result %0d: expected match=%0b found=%0b ovf=%0b, got match=%0b found=%0b ovf=%0b",
                                     checked_count, v.window_match, v.found, v.pattern_overflow,
                                     result_ch.window_match, result_ch.found,
                                     result_ch.pattern_overflow);
                    end
                end
                if (result_ch.window_match === 1'b1)
                    match_count++;
                if (result_ch.pattern_overflow === 1'b1)
                    overflow_count++;
                checked_count++;
            end
            result_ch.ready <= !take_break();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_verdicts.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void queue_letter(input int k, input int s);
        letter_req_t r;
        r.kind   = KIND_W'(k);
        r.symbol = SYM_W'(s);
        r.hold   = hold_next;
        hold_next = 1'b0;
        outgoing_letters.push_back(r);
        if (r.kind != KIND_SPARE)
            queued_count++;
    endfunction

    // one search: a clear (always for wide runs, else mostly), a pattern, then text built to hit and miss the pattern
    task automatic add_search(input bit wide);
        int pat[$];
        int perm[$];
        int plen, base, span, chunks, n, i, j, t, r, sym;
        if (wide || $urandom_range(9) != 0)
            queue_letter(KIND_CLEAR, $urandom_range(31));
        if (wide)
            plen = $urandom_range(AWM_MAX_PATTERN + 4, AWM_MAX_PATTERN);
        else if ($urandom_range(3) == 0)
            plen = $urandom_range(20, 7);
        else
            plen = $urandom_range(6, 1);
        base = $urandom_range(AWM_ALPHABET - 1);
        span = wide ? AWM_ALPHABET : $urandom_range(5, 1);
        for (i = 0; i < plen; i++)
        begin
            if (!wide && $urandom_range(29) == 0)
                sym = $urandom_range(31, AWM_ALPHABET);
            else
                sym = (base + $urandom_range(span - 1)) % AWM_ALPHABET;
            if (sym < AWM_ALPHABET && pat.size() < AWM_MAX_PATTERN)
                pat.push_back(sym);
            queue_letter(KIND_PATTERN, sym);
        end
        chunks = $urandom_range(6, 2);
        while (chunks > 0)
        begin
            chunks--;
            r = (pat.size() == 0) ? 7 : $urandom_range(9);
            if (r <= 3 || r == 9)
            begin
                perm = pat;
                for (i = perm.size() - 1; i > 0; i--)
                begin
                    j = $urandom_range(i);
                    t = perm[i];
                    perm[i] = perm[j];
                    perm[j] = t;
                end
                if (r == 9)
                    perm[$urandom_range(perm.size() - 1)] = $urandom_range(AWM_ALPHABET - 1);
                foreach (perm[k])
                    queue_letter(KIND_TEXT, perm[k]);
            end
            else if (r <= 6)
            begin
                n = $urandom_range(2 * pat.size(), 1);
                for (i = 0; i < n; i++)
                    queue_letter(KIND_TEXT, pat[$urandom_range(pat.size() - 1)]);
            end
            else if (r == 7)
            begin
                n = $urandom_range(8, 1);
                for (i = 0; i < n; i++)
                    queue_letter(KIND_TEXT, $urandom_range(AWM_ALPHABET - 1));
            end
            else
            begin
                case ($urandom_range(2))
                    0: queue_letter(KIND_TEXT, $urandom_range(31, AWM_ALPHABET));
                    1: queue_letter(KIND_SPARE, $urandom_range(31));
                    default: queue_letter(KIND_PATTERN, $urandom_range(31));
                endcase
            end
        end
    endtask

    initial
    begin
        bit first;
        int wide_runs;
        rst_n            = 1'b0;
        item_ch.valid    = 1'b0;
        item_ch.kind     = KIND_PATTERN;
        item_ch.symbol   = '0;
        result_ch.ready  = 1'b0;
        cycle_count      = 0;
        queued_count     = 0;
        accepted_count   = 0;
        checked_count    = 0;
        match_count      = 0;
        overflow_count   = 0;
        error_count      = 0;
        hold_next        = 1'b0;
        wide_runs        = 0;
        reset_search();

        // text with no pattern, unused kind, edge letters, bad pattern letter
        queue_letter(KIND_TEXT, 0);
        queue_letter(KIND_SPARE, 31);
        queue_letter(KIND_PATTERN, 0);
        queue_letter(KIND_PATTERN, 25);
        queue_letter(KIND_PATTERN, 31);
        queue_letter(KIND_TEXT, 25);
        queue_letter(KIND_TEXT, 0);
        queue_letter(KIND_TEXT, 0);
        queue_letter(KIND_TEXT, 25);
        // out-of-alphabet text empties the window, found stays
        queue_letter(KIND_TEXT, 30);
        queue_letter(KIND_TEXT, 0);
        queue_letter(KIND_TEXT, 25);
        queue_letter(KIND_SPARE, 0);
        queue_letter(KIND_CLEAR, 31);
        queue_letter(KIND_TEXT, 5);
        queue_letter(KIND_PATTERN, 3);
        queue_letter(KIND_TEXT, 3);
        queue_letter(KIND_TEXT, 4);
        queue_letter(KIND_PATTERN, 3);
        queue_letter(KIND_TEXT, 3);
        queue_letter(KIND_TEXT, 3);
        queue_letter(KIND_TEXT, 26);
        hold_next = 1'b1;

        first = 1'b1;
        while (queued_count < RANDOM_LETTERS + 22)
        begin
            if (first || $urandom_range(24) == 0)
                wide_runs++;
            add_search(first || $urandom_range(24) == 0);
            first = 1'b0;
            if (queued_count >= 1000 && queued_count < 1100)
                hold_next = 1'b1;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (outgoing_letters.size() != 0 || item_ch.valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_verdicts.size() != 0)
        begin
            $display("%0d results never arrived", expected_verdicts.size());
            error_count += expected_verdicts.size();
        end

        $display("sent %0d requests, checked %0d results in %0d cycles",
                 accepted_count, checked_count, cycle_count);
        $display("windows matched %0d, dropped pattern letters %0d, mismatches %0d",
                 match_count, overflow_count, error_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/awm_pkg.sv
hdl/awm_if.sv
hdl/awm_letter_cell.sv
hdl/awm_ring.sv
hdl/anagram_window_matcher.sv
bench/anagram_window_matcher_tb.sv
